[sv/isotp_pkg.sv]
// ----------------------------------------------------------------------------
// isotp_pkg
// shared codes, constants and control/status structs of the transport sender
// ----------------------------------------------------------------------------
package isotp_pkg;

  // default largest message that is segmented
  localparam int MAX_MESSAGE_BYTES_DEF = 4095;

  // bytes in a single frame, first frame and consecutive frame
  localparam int SF_MAX_BYTES = 7;
  localparam int FF_BYTES     = 6;
  localparam int CF_MAX_BYTES = 7;

  // input commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_FC   = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // flow control flags
  localparam logic [1:0] FC_CTS   = 2'd0;
  localparam logic [1:0] FC_WAIT  = 2'd1;
  localparam logic [1:0] FC_ABORT = 2'd2;

  // result frame kinds
  localparam logic [1:0] KIND_SF  = 2'd0;
  localparam logic [1:0] KIND_FF  = 2'd1;
  localparam logic [1:0] KIND_CF  = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;  // take the input item and update the session state
    logic issue;   // issue the next store read of the frame
    logic push;    // move the built frame into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;   // the offered item produces a frame
    logic gather_done;  // all reads of the frame are issued
    logic rd_pending;   // a read is still in flight
    logic out_free;     // the output register can be loaded now
  } sts_t;

endpackage

[sv/isotp_segmented_sender.sv]
// ----------------------------------------------------------------------------
// isotp_segmented_sender
// transport layer sender: single, first and consecutive frames of a message
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              content
//   in_*      input      in_valid / in_ready    command, byte, flow control
//   out_*     output     out_valid / out_ready  one frame or error result
//
// an item that yields no frame leaves the sequencer in idle, ready for the next
// an item that yields a frame is gathered by one store read per payload byte
// (none for an error) through the registered read port
// the output register lets the next item in while a frame waits to go out
// synchronous active-low reset, the message store itself is not cleared
// a stalled out_ready holds the sequencer before the output load only
//
module isotp_segmented_sender #(
  parameter int MAX_MESSAGE_BYTES = isotp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [1:0]  in_fc_flag,
  input  logic [7:0]  in_fc_block_size,
  input  logic [7:0]  in_fc_separation_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_kind,
  output logic [55:0] out_payload,
  output logic [2:0]  out_payload_length,
  output logic [3:0]  out_sequence_number,
  output logic [11:0] out_total_length
);

  // command and status between sequencer and datapath
  isotp_pkg::cmd_t cmd;
  isotp_pkg::sts_t sts;

  // sequencer: accept, gather reads, output load
  isotp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: session counters, store, build buffer, output register
  isotp_dp #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command          (in_command),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .in_fc_flag          (in_fc_flag),
    .in_fc_block_size    (in_fc_block_size),
    .in_fc_separation_ms (in_fc_separation_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_kind      (out_frame_kind),
    .out_payload         (out_payload),
    .out_payload_length  (out_payload_length),
    .out_sequence_number (out_sequence_number),
    .out_total_length    (out_total_length)
  );

endmodule

[sv/isotp_ram.sv]
// ----------------------------------------------------------------------------
// isotp_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module isotp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/isotp_ctrl.sv]
// ----------------------------------------------------------------------------
// isotp_ctrl
// sequencer: takes one item, walks the store reads of a frame, hands it out
// ----------------------------------------------------------------------------
module isotp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  isotp_pkg::sts_t   sts,
  output isotp_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GATHER = 2'd1;
  localparam logic [1:0] ST_PUSH   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.push   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.has_result) begin
            state_nxt = ST_GATHER;
          end
        end
      end
      ST_GATHER: begin
        if (!sts.gather_done) begin
          cmd.issue = 1'b1;
        end else if (!sts.rd_pending) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/isotp_dp.sv]
// ----------------------------------------------------------------------------
// isotp_dp
// session state, message store, frame build buffer and output register
// ----------------------------------------------------------------------------
module isotp_dp #(
  parameter int MAX_MESSAGE_BYTES = isotp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  isotp_pkg::cmd_t   cmd,
  output isotp_pkg::sts_t   sts,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic [1:0]        in_fc_flag,
  input  logic [7:0]        in_fc_block_size,
  input  logic [7:0]        in_fc_separation_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_frame_kind,
  output logic [55:0]       out_payload,
  output logic [2:0]        out_payload_length,
  output logic [3:0]        out_sequence_number,
  output logic [11:0]       out_total_length
);

  localparam int DEPTH  = MAX_MESSAGE_BYTES + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(MAX_MESSAGE_BYTES + 2);

  // session state
  logic [LEN_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [LEN_W-1:0] msg_len_r, msg_len_nxt;
  logic [LEN_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [7:0]       frames_r, frames_nxt;
  logic [7:0]       block_r, block_nxt;
  logic [7:0]       sep_r, sep_nxt;
  logic [7:0]       tick_r, tick_nxt;
  logic [3:0]       seq_r, seq_nxt;
  logic             sending_r, sending_nxt;

  // frame under construction
  logic [1:0]       kind_b_r, kind_b_nxt;
  logic [2:0]       len_b_r, len_b_nxt;
  logic [3:0]       seq_b_r, seq_b_nxt;
  logic [11:0]      total_b_r, total_b_nxt;
  logic [LEN_W-1:0] base_r, base_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic [55:0]      buf_r, buf_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r;
  logic [55:0]      out_payload_r;
  logic [2:0]       out_len_r;
  logic [3:0]       out_seq_r;
  logic [11:0]      out_total_r;

  // store access
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // decision terms
  logic             room;
  logic [LEN_W-1:0] new_cnt;
  logic [7:0]       tick_inc;
  logic [LEN_W-1:0] remain;
  logic [2:0]       cf_len;
  logic             res_valid;
  logic             is_byte;

  assign is_byte  = (in_command == isotp_pkg::CMD_BYTE);
  assign room     = (load_cnt_r < LEN_W'(DEPTH));
  assign new_cnt  = room ? load_cnt_r + LEN_W'(1) : load_cnt_r;
  assign tick_inc = (tick_r != 8'hFF) ? tick_r + 8'd1 : tick_r;
  assign remain   = msg_len_r - rd_pos_r;
  assign cf_len   = (remain > LEN_W'(isotp_pkg::CF_MAX_BYTES)) ?
                    3'(isotp_pkg::CF_MAX_BYTES) : remain[2:0];
  assign ram_we   = cmd.accept && is_byte && room;
  assign ram_raddr = ADDR_W'(base_r + LEN_W'(idx_r));

  isotp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_cnt_r[ADDR_W-1:0]),
    .wdata (in_data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    msg_len_nxt  = msg_len_r;
    rd_pos_nxt   = rd_pos_r;
    frames_nxt   = frames_r;
    block_nxt    = block_r;
    sep_nxt      = sep_r;
    tick_nxt     = tick_r;
    seq_nxt      = seq_r;
    sending_nxt  = sending_r;
    kind_b_nxt   = kind_b_r;
    len_b_nxt    = len_b_r;
    seq_b_nxt    = seq_b_r;
    total_b_nxt  = total_b_r;
    base_nxt     = base_r;
    res_valid    = 1'b0;

    case (in_command)
      isotp_pkg::CMD_BYTE: begin
        sending_nxt = 1'b0;
        msg_len_nxt = '0;
        rd_pos_nxt  = '0;
        if (!in_last_byte) begin
          load_cnt_nxt = new_cnt;
        end else begin
          load_cnt_nxt = '0;
          res_valid    = 1'b1;
          base_nxt     = '0;
          seq_b_nxt    = 4'd0;
          if (new_cnt <= LEN_W'(isotp_pkg::SF_MAX_BYTES)) begin
            kind_b_nxt  = isotp_pkg::KIND_SF;
            len_b_nxt   = new_cnt[2:0];
            total_b_nxt = 12'(new_cnt);
          end else if (new_cnt > LEN_W'(MAX_MESSAGE_BYTES)) begin
            kind_b_nxt  = isotp_pkg::KIND_ERR;
            len_b_nxt   = 3'd0;
            total_b_nxt = 12'd0;
          end else begin
            // long message: first frame, then wait for flow control
            kind_b_nxt  = isotp_pkg::KIND_FF;
            len_b_nxt   = 3'(isotp_pkg::FF_BYTES);
            total_b_nxt = 12'(new_cnt);
            msg_len_nxt = new_cnt;
            rd_pos_nxt  = LEN_W'(isotp_pkg::FF_BYTES);
            seq_nxt     = 4'd1;
            frames_nxt  = 8'd0;
            block_nxt   = 8'd0;
          end
        end
      end
      isotp_pkg::CMD_FC: begin
        if (in_fc_flag == isotp_pkg::FC_ABORT) begin
          sending_nxt = 1'b0;
        end else if (in_fc_flag == isotp_pkg::FC_CTS) begin
          frames_nxt  = 8'd0;
          block_nxt   = in_fc_block_size;
          sep_nxt     = in_fc_separation_ms;
          tick_nxt    = 8'd0;
          sending_nxt = 1'b1;
        end
      end
      isotp_pkg::CMD_TICK: begin
        if (sending_r) begin
          if (tick_inc < sep_r) begin
            tick_nxt = tick_inc;
          end else begin
            tick_nxt = 8'd0;
            if ((block_r != 8'd0 && frames_r >= block_r) || rd_pos_r >= msg_len_r) begin
              sending_nxt = 1'b0;
            end else begin
              res_valid   = 1'b1;
              kind_b_nxt  = isotp_pkg::KIND_CF;
              len_b_nxt   = cf_len;
              seq_b_nxt   = seq_r;
              total_b_nxt = 12'd0;
              base_nxt    = rd_pos_r;
              rd_pos_nxt  = rd_pos_r + LEN_W'(cf_len);
              seq_nxt     = seq_r + 4'd1;
              frames_nxt  = frames_r + 8'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // read sequencing and byte placement
  always_comb begin
    idx_nxt      = idx_r;
    slot_nxt     = slot_r;
    rd_valid_nxt = 1'b0;
    buf_nxt      = buf_r;
    if (rd_valid_r) begin
      buf_nxt[slot_r*8 +: 8] = ram_rdata;
    end
    if (cmd.accept) begin
      idx_nxt = 3'd0;
      buf_nxt = '0;
    end else if (cmd.issue) begin
      idx_nxt      = idx_r + 3'd1;
      slot_nxt     = idx_r;
      rd_valid_nxt = 1'b1;
    end
  end

  assign out_valid_nxt = cmd.push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  assign sts.has_result  = res_valid;
  assign sts.gather_done = (idx_r == len_b_r);
  assign sts.rd_pending  = rd_valid_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      msg_len_r   <= '0;
      rd_pos_r    <= '0;
      frames_r    <= 8'd0;
      block_r     <= 8'd0;
      sep_r       <= 8'd0;
      tick_r      <= 8'd0;
      seq_r       <= 4'd1;
      sending_r   <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        load_cnt_r <= load_cnt_nxt;
        msg_len_r  <= msg_len_nxt;
        rd_pos_r   <= rd_pos_nxt;
        frames_r   <= frames_nxt;
        block_r    <= block_nxt;
        sep_r      <= sep_nxt;
        tick_r     <= tick_nxt;
        seq_r      <= seq_nxt;
        sending_r  <= sending_nxt;
      end
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && res_valid) begin
      kind_b_r  <= kind_b_nxt;
      len_b_r   <= len_b_nxt;
      seq_b_r   <= seq_b_nxt;
      total_b_r <= total_b_nxt;
      base_r    <= base_nxt;
    end
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    buf_r  <= buf_nxt;
    if (cmd.push) begin
      out_kind_r    <= kind_b_r;
      out_payload_r <= buf_r;
      out_len_r     <= len_b_r;
      out_seq_r     <= seq_b_r;
      out_total_r   <= total_b_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_kind      = out_kind_r;
  assign out_payload         = out_payload_r;
  assign out_payload_length  = out_len_r;
  assign out_sequence_number = out_seq_r;
  assign out_total_length    = out_total_r;

endmodule

[sv/isotp_checker.sv]
// ----------------------------------------------------------------------------
// isotp_checker
// port-level checks of the transport sender, bound to the top level
// ----------------------------------------------------------------------------
module isotp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_frame_kind,
  input logic [55:0] out_payload,
  input logic [2:0]  out_payload_length,
  input logic [3:0]  out_sequence_number,
  input logic [11:0] out_total_length
);

  // stalled frame holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)
      && $stable(out_frame_kind) && $stable(out_payload_length))
    else $error("stalled frame changed");

  // error result carries nothing
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == isotp_pkg::KIND_ERR |->
      out_payload == 56'd0 && out_payload_length == 3'd0 && out_total_length == 12'd0)
    else $error("error result not empty");

  // single frame length matches the message length
  a_sf_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == isotp_pkg::KIND_SF |->
      out_total_length == 12'(out_payload_length) && out_sequence_number == 4'd0)
    else $error("single frame length mismatch");

  // first frame carries six bytes of a long message
  a_ff_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind == isotp_pkg::KIND_FF |->
      out_payload_length == 3'(isotp_pkg::FF_BYTES) && out_total_length > 12'd7)
    else $error("first frame malformed");

endmodule

bind isotp_segmented_sender isotp_checker u_isotp_checker (.*);

[tb/tb_isotp_segmented_sender.sv]
// ----------------------------------------------------------------------------
// tb_isotp_segmented_sender
// self-checking bench for the transport sender: directed frame cases, the
// length limits and random sessions, with every transfer checked against a
// behavioral frame predictor kept inside the bench
// ----------------------------------------------------------------------------
module tb_isotp_segmented_sender;
  import isotp_pkg::*;

  // codes the package leaves unnamed, both ignored by the block
  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam logic [1:0] FC_RESERVED = 2'd3;

  localparam int STORE_DEPTH    = 4096;
  localparam int MAX_BYTES      = MAX_MESSAGE_BYTES_DEF;
  localparam int RANDOM_ITEMS   = 700;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_PRINTED    = 40;
  localparam longint TIMEOUT_UNITS = 64'd60_000_000;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  // one expected frame, field by field
  typedef struct packed {
    logic [1:0]  kind;
    logic [55:0] payload;
    logic [2:0]  plen;
    logic [3:0]  seq;
    logic [11:0] total;
  } frame_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic [1:0]  in_fc_flag;
  logic [7:0]  in_fc_block_size;
  logic [7:0]  in_fc_separation_ms;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_frame_kind;
  logic [55:0] out_payload;
  logic [2:0]  out_payload_length;
  logic [3:0]  out_sequence_number;
  logic [11:0] out_total_length;

  isotp_segmented_sender DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .in_fc_flag          (in_fc_flag),
    .in_fc_block_size    (in_fc_block_size),
    .in_fc_separation_ms (in_fc_separation_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_kind      (out_frame_kind),
    .out_payload         (out_payload),
    .out_payload_length  (out_payload_length),
    .out_sequence_number (out_sequence_number),
    .out_total_length    (out_total_length)
  );

  // 10 unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a shadow copy of the sender session
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_store [STORE_DEPTH];
  logic [12:0] bytes_loaded;     // saturates at the store depth
  logic [11:0] pending_len;      // length of the multi-frame message, 0 if none
  logic [11:0] next_offset;      // next byte to go out in a consecutive frame
  logic [7:0]  block_frames;
  logic [7:0]  block_size;
  logic [7:0]  sep_ms;
  logic [7:0]  ms_count;
  logic [3:0]  next_seq;
  bit          sending;

  frame_t expected_frames[$];    // frames still owed by the block, oldest first
  int     error_count;
  int     counted_items;         // transfers that change the session
  idle_e  tx_mode;
  idle_e  rx_mode;

  // per-item wait, shaped by the idle mode of the phase
  function automatic int draw_wait(idle_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
      default:    return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic idle_e draw_mode();
    case ($urandom_range(0, 3))
      0:       return IDLE_NONE;
      1:       return IDLE_LIGHT;
      default: return IDLE_FULL;
    endcase
  endfunction

  // up to seven stored bytes, first byte in the low bits
  function automatic logic [55:0] gather_bytes(logic [11:0] start, int count);
    logic [55:0] v;
    v = '0;
    for (int i = 0; i < count && i < CF_MAX_BYTES; i++)
      v[8*i +: 8] = shadow_store[12'(start + i)];
    return v;
  endfunction

  function automatic void expect_frame(logic [1:0] kind, logic [55:0] payload,
                                       int plen, logic [3:0] seq, int total);
    frame_t f;
    f.kind    = kind;
    f.payload = payload;
    f.plen    = 3'(plen);
    f.seq     = seq;
    f.total   = 12'(total);
    expected_frames.push_back(f);
  endfunction

  // advance the shadow session by one accepted item, queue the frame it owes
  function automatic void predict_frame(logic [1:0] cmd, logic [7:0] data, logic last,
                                        logic [1:0] flag, logic [7:0] bs, logic [7:0] sep);
    int n;
    int remaining;
    case (cmd)
      CMD_BYTE: begin
        // any byte ends a running transfer and drops the pending message
        sending     = 1'b0;
        pending_len = '0;
        next_offset = '0;
        if (bytes_loaded < STORE_DEPTH) begin
          shadow_store[bytes_loaded[11:0]] = data;
          bytes_loaded++;
        end
        if (last) begin
          n = bytes_loaded;
          bytes_loaded = '0;
          if (n <= SF_MAX_BYTES) begin
            expect_frame(KIND_SF, gather_bytes('0, n), n, '0, n);
          end else if (n > MAX_BYTES) begin
            expect_frame(KIND_ERR, '0, 0, '0, 0);
          end else begin
            pending_len  = 12'(n);
            next_offset  = 12'(FF_BYTES);
            next_seq     = 4'd1;
            block_frames = '0;
            block_size   = '0;
            expect_frame(KIND_FF, gather_bytes('0, FF_BYTES), FF_BYTES, '0, n);
          end
        end
      end
      CMD_FC: begin
        if (flag == FC_ABORT) begin
          sending = 1'b0;
        end else if (flag == FC_CTS) begin
          block_frames = '0;
          block_size   = bs;
          sep_ms       = sep;
          ms_count     = '0;
          sending      = 1'b1;
        end
      end
      CMD_TICK: begin
        if (sending) begin
          ms_count = (ms_count < 8'd255) ? ms_count + 8'd1 : 8'd255;
          if (ms_count >= sep_ms) begin
            ms_count = '0;
            // block used up or nothing left: stop quietly
            if ((block_size != 0 && block_frames >= block_size) ||
                next_offset >= pending_len) begin
              sending = 1'b0;
            end else begin
              remaining = pending_len - next_offset;
              n = (remaining > CF_MAX_BYTES) ? CF_MAX_BYTES : remaining;
              expect_frame(KIND_CF, gather_bytes(next_offset, n), n, next_seq, 0);
              next_offset  = next_offset + 12'(n);
              next_seq     = next_seq + 4'd1;
              block_frames = block_frames + 8'd1;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driving side
  // ---------------------------------------------------------------------------
  // one input transfer: idle gap, present at the falling edge, hold until taken
  task automatic send_item(logic [1:0] cmd, logic [7:0] data, logic last,
                           logic [1:0] flag, logic [7:0] bs, logic [7:0] sep);
    int gap;
    bit ignored;
    gap = draw_wait(tx_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_data_byte        <= data;
    in_last_byte        <= last;
    in_fc_flag          <= flag;
    in_fc_block_size    <= bs;
    in_fc_separation_ms <= sep;
    do @(posedge clk); while (!in_ready);
    ignored = (cmd == CMD_NONE) ||
              (cmd == CMD_FC && (flag == FC_WAIT || flag == FC_RESERVED)) ||
              (cmd == CMD_TICK && !sending);
    if (!ignored) counted_items++;
    predict_frame(cmd, data, last, flag, bs, sep);
  endtask

  // fields that the command does not use still carry random bits
  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom), 1'($urandom), 2'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic send_fc(logic [1:0] flag, logic [7:0] bs, logic [7:0] sep);
    send_item(CMD_FC, 8'($urandom), 1'($urandom), flag, bs, sep);
  endtask

  task automatic send_noise();
    send_item(2'($urandom), 8'($urandom), 1'($urandom), 2'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic load_message(int len, fill_e fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      send_item(CMD_BYTE, b, i == len - 1, 2'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // hold the input idle until every owed frame has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // ticks until the shadow session stops sending
  task automatic tick_until_stopped();
    while (sending) send_tick();
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random stalls, one draw per transfer
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait(rx_mode);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (error_count < MAX_PRINTED)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // compare each result transfer with the oldest owed frame
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected frame kind", out_frame_kind, 0);
      end else begin
        want = expected_frames.pop_front();
        if (out_frame_kind !== want.kind)
          report_mismatch("frame_kind", out_frame_kind, want.kind);
        if (out_payload !== want.payload)
          report_mismatch("payload", out_payload, want.payload);
        if (out_payload_length !== want.plen)
          report_mismatch("payload_length", out_payload_length, want.plen);
        if (out_sequence_number !== want.seq)
          report_mismatch("sequence_number", out_sequence_number, want.seq);
        if (out_total_length !== want.total)
          report_mismatch("total_length", out_total_length, want.total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // single frames at both length ends, plus items the block ignores
  task automatic test_single_frames();
    load_message(1, FILL_ONES);
    load_message(7, FILL_ZERO);
    load_message(7, FILL_RANDOM);
    send_tick();                                  // tick with nothing running
    send_item(CMD_NONE, 8'hFF, 1'b1, FC_RESERVED, 8'hFF, 8'hFF);
  endtask

  // first frame, then paced consecutive frames in blocks
  task automatic test_segmented_transfer();
    load_message(22, FILL_ONES);                  // first frame plus 7, 7, 2
    send_fc(FC_WAIT, 8'd1, 8'd0);                 // wait flag does nothing
    send_fc(FC_RESERVED, 8'd1, 8'd0);
    send_tick();
    send_fc(FC_CTS, 8'd2, 8'd2);                  // two frames, every second tick
    repeat (6) send_tick();                       // last paced tick ends the block
    send_fc(FC_CTS, 8'd0, 8'd0);                  // unlimited block, every tick
    tick_until_stopped();
    send_fc(FC_CTS, 8'd0, 8'd1);                  // nothing left to send
    tick_until_stopped();
  endtask

  // abort and a byte load both stop a running transfer
  task automatic test_flow_control();
    load_message(15, FILL_ZERO);
    send_fc(FC_CTS, 8'd255, 8'd0);
    send_tick();
    send_fc(FC_ABORT, 8'd0, 8'd0);
    send_tick();                                  // ignored after abort
    send_fc(FC_CTS, 8'd255, 8'd0);
    tick_until_stopped();
    load_message(9, FILL_RANDOM);
    send_fc(FC_CTS, 8'd0, 8'd0);
    load_message(1, FILL_RANDOM);                 // drops the pending message
    send_tick();
  endtask

  // slowest pacing: one frame per 255 ticks, then the block ends
  task automatic test_slowest_separation();
    tx_mode = IDLE_NONE;
    load_message(8, FILL_RANDOM);
    send_fc(FC_CTS, 8'd1, 8'd255);
    tick_until_stopped();
    tx_mode = IDLE_FULL;
  endtask

  // largest legal message, then overlong ones that saturate the load count
  task automatic test_length_limits();
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_LIGHT;
    load_message(MAX_BYTES, FILL_RANDOM);
    send_fc(FC_CTS, 8'd0, 8'd0);
    tick_until_stopped();                         // sequence number wraps many times
    load_message(MAX_BYTES + 1, FILL_RANDOM);
    load_message(MAX_BYTES + 5, FILL_RANDOM);
    send_fc(FC_CTS, 8'd3, 8'd0);                  // clear to send with nothing pending
    tick_until_stopped();
    load_message(8, FILL_RANDOM);                 // normal again after the error
    drain_results();
  endtask

  // one well-formed session: load, then blocks of frames until done
  task automatic run_session();
    int len;
    int r;
    logic [7:0] bs;
    logic [7:0] sep;
    r = $urandom_range(0, 19);
    if (r < 5)       len = $urandom_range(1, 7);
    else if (r < 17) len = $urandom_range(8, 60);
    else             len = $urandom_range(61, 300);
    load_message(len, FILL_RANDOM);
    while (pending_len != 0 && next_offset < pending_len) begin
      r = $urandom_range(0, 9);
      if (r < 3)       bs = 8'd0;
      else if (r < 8)  bs = 8'($urandom_range(1, 4));
      else if (r == 8) bs = 8'd255;
      else             bs = 8'($urandom);
      r = $urandom_range(0, 39);
      if (r < 36)      sep = 8'($urandom_range(0, 3));
      else if (r < 39) sep = 8'($urandom_range(4, 20));
      else             sep = 8'($urandom_range(21, 255));
      send_fc(FC_CTS, bs, sep);
      while (sending) begin
        if ($urandom_range(0, 24) == 0) send_noise();
        else send_tick();
      end
      if ($urandom_range(0, 15) == 0) break;     // receiver gives up on the message
    end
  endtask

  task automatic test_random_traffic();
    int target;
    target = counted_items + RANDOM_ITEMS;
    while (counted_items < target) begin
      tx_mode = draw_mode();
      rx_mode = draw_mode();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        run_session();
      end
      // sender holds off until the block has caught up
      if ($urandom_range(0, 14) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid            = 1'b0;
    in_command          = CMD_NONE;
    in_data_byte        = '0;
    in_last_byte        = 1'b0;
    in_fc_flag          = FC_CTS;
    in_fc_block_size    = '0;
    in_fc_separation_ms = '0;
    rst_n               = 1'b0;
    error_count         = 0;
    counted_items       = 0;
    tx_mode             = IDLE_FULL;
    rx_mode             = IDLE_FULL;
    bytes_loaded        = '0;
    pending_len         = '0;
    next_offset         = '0;
    block_frames        = '0;
    block_size          = '0;
    sep_ms              = '0;
    ms_count            = '0;
    next_seq            = 4'd1;
    sending             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_frames();
    test_segmented_transfer();
    test_flow_control();
    test_slowest_separation();
    test_length_limits();
    test_random_traffic();

    drain_results();
    // a late item that owes nothing may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0)
      report_mismatch("frames never delivered", expected_frames.size(), 0);
    if (error_count == 0)
      $display("tb_isotp_segmented_sender passed");
    else
      $display("tb_isotp_segmented_sender failed");
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_UNITS);
    $display("tb_isotp_segmented_sender failed");
    $finish;
  end

endmodule

[isotp_segmented_sender.f]
sv/isotp_pkg.sv
sv/isotp_ram.sv
sv/isotp_ctrl.sv
sv/isotp_dp.sv
sv/isotp_segmented_sender.sv
sv/isotp_checker.sv
tb/tb_isotp_segmented_sender.sv
